/* sv/spi_write_serializer_with_dc_unit_macros.svh */
// assertion macros shared by the serializer rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SPI_WRITE_SERIALIZER_WITH_DC_UNIT_MACROS_SVH
`define SPI_WRITE_SERIALIZER_WITH_DC_UNIT_MACROS_SVH

// consequence checked on the same edge
`define SWDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked on the following edge
`define SWDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/swdc_pkg.sv */
// shared types and constants of the spi write serializer
// no dependencies
package swdc_pkg;

  localparam int WORD_W            = 32;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 1;
  localparam int CNT_W             = 16;
  localparam int WIDTH_CODE_W      = 2;
  localparam int QUEUE_DEPTH       = 2;
  localparam int MAX_WORD_BITS_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLK_HIGH = 1'b0,
    CFG_CLK_LOW  = 1'b1
  } cfg_idx_e;

  typedef enum logic [WIDTH_CODE_W-1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } width_e;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } action_e;

  // classified request as it travels through the queue
  typedef struct packed {
    logic              is_start;
    logic [WORD_W-1:0] word;     // left aligned, msb first
    logic              dc;
    logic              eof;
  } cmd_t;

  typedef struct packed {
    logic sclk;
    logic sdata;
    logic cs_level;
    logic dc_level;
    logic busy_res;
    logic done_res;
    logic rejected;
  } res_t;

endpackage

/* sv/swdc_intf.sv */
// request and result channel interfaces of the spi write serializer
// depends on swdc_pkg
interface swdc_req_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [swdc_pkg::WORD_W-1:0]        word;
  logic [swdc_pkg::WIDTH_CODE_W-1:0]  width_code;
  logic                               is_data;
  logic                               end_of_frame;

  modport source (output valid, action, word, width_code, is_data, end_of_frame,
                  input ready);
  modport sink   (input valid, action, word, width_code, is_data, end_of_frame,
                  output ready);
endinterface

interface swdc_res_if;
  logic valid;
  logic ready;
  logic sclk;
  logic sdata;
  logic cs_level;
  logic dc_level;
  logic busy_res;
  logic done_res;
  logic rejected;

  modport source (output valid, sclk, sdata, cs_level, dc_level, busy_res, done_res,
                  rejected, input ready);
  modport sink   (input valid, sclk, sdata, cs_level, dc_level, busy_res, done_res,
                  rejected, output ready);
endinterface

/* sv/swdc_front.sv */
// front end: takes requests, decodes width and aligns the word
// depends on swdc_pkg and swdc_req_if
module swdc_front #(
  parameter int MaxWordBits = swdc_pkg::MAX_WORD_BITS_DEF,
  parameter int BitsW       = $clog2(MaxWordBits + 1)
) (
  swdc_req_if.sink           req_i,
  input  logic               q_ready_i,
  output logic               q_push_o,
  output swdc_pkg::cmd_t     cmd_o,
  output logic [BitsW-1:0]   nbits_o
);

  localparam int Bits8  = (8 < MaxWordBits) ? 8 : MaxWordBits;
  localparam int Bits16 = (16 < MaxWordBits) ? 16 : MaxWordBits;
  localparam int Bits32 = (32 < MaxWordBits) ? 32 : MaxWordBits;
  localparam int Sh8    = swdc_pkg::WORD_W - Bits8;
  localparam int Sh16   = swdc_pkg::WORD_W - Bits16;
  localparam int Sh32   = swdc_pkg::WORD_W - Bits32;

  assign req_i.ready = q_ready_i;
  assign q_push_o    = req_i.valid && q_ready_i;

  // shifting up drops the bits above the width, which masks the word
  always_comb begin
    cmd_o.is_start = (req_i.action == swdc_pkg::ACT_START);
    cmd_o.dc       = req_i.is_data;
    cmd_o.eof      = req_i.end_of_frame;
    case (req_i.width_code)
      swdc_pkg::WIDTH_8: begin
        cmd_o.word = req_i.word << Sh8;
        nbits_o    = BitsW'(Bits8);
      end
      swdc_pkg::WIDTH_16: begin
        cmd_o.word = req_i.word << Sh16;
        nbits_o    = BitsW'(Bits16);
      end
      default: begin
        cmd_o.word = req_i.word << Sh32;
        nbits_o    = BitsW'(Bits32);
      end
    endcase
  end

endmodule

/* sv/swdc_queue.sv */
// short fifo between the front end and the shift engine
// depends on swdc_pkg
module swdc_queue #(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [DataW-1:0] pop_data_o
);

  localparam int Depth = swdc_pkg::QUEUE_DEPTH;
  localparam int AddrW = $clog2(Depth);

  logic [DataW-1:0]   mem_q [Depth];
  logic [AddrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]     count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != (AddrW+1)'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + (AddrW+1)'(do_push) - (AddrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/swdc_back.sv */
// shift engine: timing registers, pin state and the result register
// depends on swdc_pkg, swdc_res_if and the assertion macro header
`include "spi_write_serializer_with_dc_unit_macros.svh"

module swdc_back #(
  parameter int MaxWordBits = swdc_pkg::MAX_WORD_BITS_DEF,
  parameter int BitsW       = $clog2(MaxWordBits + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swdc_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            q_valid_i,
  input  swdc_pkg::cmd_t                  q_cmd_i,
  input  logic [BitsW-1:0]                q_nbits_i,
  output logic                            q_pop_o,
  swdc_res_if.source                      res_o
);

  localparam int W = swdc_pkg::WORD_W;

  logic [swdc_pkg::CFG_W-1:0] hi_ticks_q, lo_ticks_q;
  logic [swdc_pkg::CFG_W-1:0] hi_eff, lo_eff;

  logic [W-1:0]                shift_q, shift_d;
  logic [BitsW-1:0]            bits_q, bits_d;
  logic [swdc_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic                        high_q, high_d;
  logic                        busy_q, busy_d;
  logic                        sel_q, sel_d;
  logic                        dc_q, dc_d;
  logic                        data_q, data_d;
  logic                        eof_q, eof_d;
  logic                        done, rej, take;

  logic                        out_valid_q;
  swdc_pkg::res_t              res_q, res_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_ticks_q <= swdc_pkg::CFG_W'(1);
      lo_ticks_q <= swdc_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      case (swdc_pkg::cfg_idx_e'(cfg_idx_i))
        swdc_pkg::CFG_CLK_HIGH: hi_ticks_q <= cfg_data_i;
        swdc_pkg::CFG_CLK_LOW:  lo_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign hi_eff = (hi_ticks_q == '0) ? swdc_pkg::CFG_W'(1) : hi_ticks_q;
  assign lo_eff = (lo_ticks_q == '0) ? swdc_pkg::CFG_W'(1) : lo_ticks_q;

  // a request is taken whenever the result register is free or drains
  assign take    = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = take;
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    shift_d = shift_q;
    bits_d  = bits_q;
    cnt_d   = cnt_q;
    high_d  = high_q;
    busy_d  = busy_q;
    sel_d   = sel_q;
    dc_d    = dc_q;
    data_d  = data_q;
    eof_d   = eof_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (take) begin
      if (q_cmd_i.is_start) begin
        if (busy_q) begin
          rej = 1'b1;
        end else begin
          shift_d = q_cmd_i.word;
          bits_d  = q_nbits_i;
          eof_d   = q_cmd_i.eof;
          dc_d    = q_cmd_i.dc;
          sel_d   = 1'b0;
          busy_d  = 1'b1;
          data_d  = q_cmd_i.word[W-1];
          high_d  = 1'b1;
          cnt_d   = '0;
        end
      end else if (busy_q) begin
        cnt_d = cnt_inc;
        if (high_q) begin
          if (cnt_inc >= hi_eff) begin
            high_d = 1'b0;
            cnt_d  = '0;
          end
        end else if (cnt_inc >= lo_eff) begin
          cnt_d  = '0;
          bits_d = bits_q - 1'b1;
          if (bits_d == '0) begin
            busy_d = 1'b0;
            done   = 1'b1;
            if (eof_q) begin
              sel_d = 1'b1;
            end
            eof_d = 1'b0;
          end else begin
            // next bit goes out with the rising clock
            shift_d = shift_q << 1;
            data_d  = shift_q[W-2];
            high_d  = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res_d.sclk     = busy_d && high_d;
    res_d.sdata    = data_d;
    res_d.cs_level = sel_d;
    res_d.dc_level = dc_d;
    res_d.busy_res = busy_d;
    res_d.done_res = done;
    res_d.rejected = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      cnt_q       <= '0;
      high_q      <= 1'b0;
      busy_q      <= 1'b0;
      sel_q       <= 1'b1;
      dc_q        <= 1'b0;
      data_q      <= 1'b0;
      eof_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      high_q <= high_d;
      busy_q <= busy_d;
      sel_q  <= sel_d;
      dc_q   <= dc_d;
      data_q <= data_d;
      eof_q  <= eof_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.sclk     = res_q.sclk;
  assign res_o.sdata    = res_q.sdata;
  assign res_o.cs_level = res_q.cs_level;
  assign res_o.dc_level = res_q.dc_level;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.done_res = res_q.done_res;
  assign res_o.rejected = res_q.rejected;

  `SWDC_ASSERT_SAME(a_cs_low_while_busy, busy_q, !sel_q, "chip select high during a word")
  `SWDC_ASSERT_SAME(a_bits_left_when_busy, busy_q, bits_q != '0, "busy with no bits left")
  `SWDC_ASSERT_NEXT(a_start_loads, take && q_cmd_i.is_start && !busy_q, busy_q && high_q,
                    "accepted start did not begin a word")
  `SWDC_ASSERT_SAME(a_done_not_busy, out_valid_q && res_q.done_res, !res_q.busy_res,
                    "done reported while still busy")

endmodule

/* sv/spi_write_serializer_with_dc_unit.sv */
// write-only spi mode-1 serializer with a command/data line
//
// req_i carries one request per handshake: a time tick, or a start with a word of
// 8, 16 or 32 bits, the command/data level and an end-of-frame flag. res_o returns
// exactly one result per request: the pin levels (sclk, sdata, cs_level, dc_level)
// after that request, plus busy, done and rejected flags. configuration (serial clock high
// and low times in ticks, zero acting as one) must be written on the cfg port only while
// idle; the block does not enforce this. a request passes through the queue and then the
// result register before its result is valid. one request is taken every cycle while the
// queue has room; the two-entry queue between the decoder and the shift engine, and the
// result register after it, keep the request side moving while a result waits. pin timing
// advances only on ticks. when the result side stalls, the engine holds and the queue
// fills, after which req_i.ready drops until the result is taken. at reset chip select
// is high, the clock and data low, both timing registers are one and the queue is empty.
// depends on swdc_pkg, swdc_intf, swdc_front, swdc_queue and swdc_back
module spi_write_serializer_with_dc_unit #(
  parameter int MAX_WORD_BITS = swdc_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  swdc_req_if.sink                        req_i,
  swdc_res_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [swdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swdc_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int BitsW = $clog2(MAX_WORD_BITS + 1);
  localparam int QW    = $bits(swdc_pkg::cmd_t) + BitsW;

  swdc_pkg::cmd_t     f_cmd, q_cmd;
  logic [BitsW-1:0]   f_nbits, q_nbits;
  logic               f_push, q_ready, q_valid, q_pop;
  logic [QW-1:0]      q_data;

  swdc_front #(
    .MaxWordBits (MAX_WORD_BITS),
    .BitsW       (BitsW)
  ) u_front (
    .req_i     (req_i),
    .q_ready_i (q_ready),
    .q_push_o  (f_push),
    .cmd_o     (f_cmd),
    .nbits_o   (f_nbits)
  );

  swdc_queue #(
    .DataW (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_push),
    .push_data_i  ({f_cmd, f_nbits}),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data)
  );

  assign q_cmd   = swdc_pkg::cmd_t'(q_data[QW-1:BitsW]);
  assign q_nbits = q_data[BitsW-1:0];

  swdc_back #(
    .MaxWordBits (MAX_WORD_BITS),
    .BitsW       (BitsW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_nbits_i  (q_nbits),
    .q_pop_o    (q_pop),
    .res_o      (res_o)
  );

endmodule
